@@ hdl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg - shared types and constants for the source token scanner
// Request structs, token kinds, scan modes and keyword prefix tracking.
// ----------------------------------------------------------------------------
`default_nettype none
package sts_pkg;

	localparam int POSITION_BITS = 24;
	localparam int LENGTH_BITS   = 16;
	localparam int LINE_BITS     = 20;

	localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = {LENGTH_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]     LINE_MAX = {LINE_BITS{1'b1}};

	typedef enum logic [4:0] {
		TK_EOF = 5'd0, TK_ERROR = 5'd1, TK_ID = 5'd2, TK_NUMBER = 5'd3,
		TK_QNUMBER = 5'd4, TK_STRING = 5'd5, TK_MAIN = 5'd6, TK_FN = 5'd7,
		TK_TRUE = 5'd8, TK_FALSE = 5'd9, TK_TYPE = 5'd10, TK_QTRUE = 5'd11,
		TK_QFALSE = 5'd12, TK_LBRACE = 5'd13, TK_RBRACE = 5'd14,
		TK_LPAREN = 5'd15, TK_RPAREN = 5'd16, TK_LBRACK = 5'd17,
		TK_RBRACK = 5'd18, TK_LT = 5'd19, TK_GT = 5'd20, TK_COLON = 5'd21,
		TK_EQ = 5'd22, TK_DOT = 5'd23
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0, ERR_UNTERM = 2'd1, ERR_UNEXPECTED = 2'd2
	} err_kind_t;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0, M_IDENT = 3'd1, M_INT = 3'd2, M_FRAC = 3'd3,
		M_STRING = 3'd4, M_COMMENT = 3'd5
	} scan_mode_t;

	typedef enum logic [1:0] {
		H_NONE = 2'd0, H_DOT = 2'd1, H_SLASH = 2'd2, H_AT = 2'd3
	} held_t;

	localparam logic [4:0] KW_NONE = 5'd31;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_end;
	} in_req_t;

	typedef struct packed {
		logic [4:0]               token_kind;
		logic [POSITION_BITS-1:0] token_offset;
		logic [LENGTH_BITS-1:0]   token_length;
		logic [LINE_BITS-1:0]     line_number;
		logic [1:0]               error_kind;
		logic                     last_of_run;
	} out_req_t;

	// A run of up to three tokens from one byte, queued as one entry
	typedef struct packed {
		logic [1:0] count;
		out_req_t   t0;
		out_req_t   t1;
		out_req_t   t2;
	} run_t;

	// Keyword prefix trie: state index after character c
	function automatic logic [4:0] kw_next(input logic [4:0] s, input logic [7:0] c);
		logic [4:0] r;
		r = KW_NONE;
		case (s)
			5'd0: begin
				if (c == "m") r = 5'd1;
				else if (c == "f") r = 5'd5;
				else if (c == "t") r = 5'd11;
			end
			5'd1: if (c == "a") r = 5'd2;
			5'd2: if (c == "i") r = 5'd3;
			5'd3: if (c == "n") r = 5'd4;
			5'd5: begin
				if (c == "n") r = 5'd6;
				else if (c == "a") r = 5'd7;
			end
			5'd7: if (c == "l") r = 5'd8;
			5'd8: if (c == "s") r = 5'd9;
			5'd9: if (c == "e") r = 5'd10;
			5'd11: begin
				if (c == "r") r = 5'd12;
				else if (c == "y") r = 5'd15;
			end
			5'd12: if (c == "u") r = 5'd13;
			5'd13: if (c == "e") r = 5'd14;
			5'd15: if (c == "p") r = 5'd16;
			5'd16: if (c == "e") r = 5'd17;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] kw_kind(input logic [4:0] s);
		logic [4:0] k;
		case (s)
			5'd4:    k = TK_MAIN;
			5'd6:    k = TK_FN;
			5'd10:   k = TK_FALSE;
			5'd14:   k = TK_TRUE;
			5'd17:   k = TK_TYPE;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"[":     k = TK_LBRACK;
			"]":     k = TK_RBRACK;
			"<":     k = TK_LT;
			">":     k = TK_GT;
			":":     k = TK_COLON;
			"=":     k = TK_EQ;
			".":     k = TK_DOT;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

	function automatic logic char_letter(input logic [7:0] c);
		return (c inside {["a":"z"], ["A":"Z"]}) || c == "_";
	endfunction

	function automatic logic char_numeral(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic [LENGTH_BITS-1:0] span(input logic [POSITION_BITS-1:0] e,
		input logic [POSITION_BITS-1:0] b);
		logic [POSITION_BITS-1:0] d;
		d = (e >= b) ? e - b : '0;
		if (POSITION_BITS > LENGTH_BITS && (d >> LENGTH_BITS) != '0)
			return LEN_MAX;
		return LENGTH_BITS'(d);
	endfunction

endpackage
`default_nettype wire

@@ hdl/sts_front.sv @@
// ----------------------------------------------------------------------------
// sts_front - byte classifier and scan state
// Takes one byte per cycle unless run_full, producing the run it completes.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sts_pkg::in_req_t  in_req,
	output logic                   run_valid,
	input  wire logic              run_full,
	output sts_pkg::run_t          run
);
	localparam int PB = sts_pkg::POSITION_BITS;
	localparam int LB = sts_pkg::LINE_BITS;
	localparam int NB = sts_pkg::LENGTH_BITS;

	sts_pkg::scan_mode_t mode_q, mode_d;
	sts_pkg::held_t      held_q, held_d;
	logic [PB-1:0] begin_q, begin_d, pos_q, pos_d;
	logic [LB-1:0] line_q, line_d;
	logic [4:0]    kw_q, kw_d;
	logic          qp_q, qp_d;
	logic          fire;

	assign in_stall  = run_full;
	assign fire      = in_valid && !run_full;

	// token builder working variables
	sts_pkg::out_req_t tk [3];
	logic [1:0] n;

	always_comb begin
		logic [7:0] c;
		logic [PB-1:0] p;
		logic [4:0] k;
		logic done;
		logic fresh;
		c = in_req.char_byte;
		p = pos_q;
		mode_d = mode_q; held_d = held_q; begin_d = begin_q; pos_d = pos_q;
		line_d = line_q; kw_d = kw_q; qp_d = qp_q;
		n = 2'd0;
		done = 1'b0;
		fresh = 1'b0;
		k = 5'd0;
		for (int i = 0; i < 3; i++) tk[i] = '0;

		if (in_req.is_end || c == 8'd0) begin
			case (mode_q)
				sts_pkg::M_IDLE:
					if (held_q == sts_pkg::H_SLASH || held_q == sts_pkg::H_AT) begin
						tk[n] = '{sts_pkg::TK_ERROR, begin_q, NB'(1), line_q,
							sts_pkg::ERR_UNEXPECTED, 1'b0};
						n = n + 2'd1;
					end
				sts_pkg::M_IDENT: begin
					k = sts_pkg::kw_kind(kw_q);
					tk[n] = '{5'd0, begin_q, sts_pkg::span(p, begin_q), line_q,
						sts_pkg::ERR_NONE, 1'b0};
					if (qp_q) begin
						if (k == sts_pkg::TK_TRUE) tk[n].token_kind = sts_pkg::TK_QTRUE;
						else if (k == sts_pkg::TK_FALSE) tk[n].token_kind = sts_pkg::TK_QFALSE;
						else begin
							tk[n].token_kind = sts_pkg::TK_ERROR;
							tk[n].error_kind = sts_pkg::ERR_UNEXPECTED;
						end
					end else tk[n].token_kind = (k != 5'd0) ? k : sts_pkg::TK_ID;
					n = n + 2'd1;
				end
				sts_pkg::M_INT, sts_pkg::M_FRAC: begin
					if (held_q == sts_pkg::H_DOT && mode_q == sts_pkg::M_INT) begin
						tk[n] = '{qp_q ? sts_pkg::TK_QNUMBER : sts_pkg::TK_NUMBER, begin_q,
							sts_pkg::span(p - PB'(1), begin_q), line_q, sts_pkg::ERR_NONE, 1'b0};
						n = n + 2'd1;
						tk[n] = '{sts_pkg::TK_DOT, p - PB'(1), NB'(1), line_q,
							sts_pkg::ERR_NONE, 1'b0};
						n = n + 2'd1;
					end else begin
						tk[n] = '{qp_q ? sts_pkg::TK_QNUMBER : sts_pkg::TK_NUMBER, begin_q,
							sts_pkg::span(p, begin_q), line_q, sts_pkg::ERR_NONE, 1'b0};
						n = n + 2'd1;
					end
				end
				sts_pkg::M_STRING: begin
					tk[n] = '{sts_pkg::TK_ERROR, begin_q, sts_pkg::span(p, begin_q), line_q,
						sts_pkg::ERR_UNTERM, 1'b0};
					n = n + 2'd1;
				end
				default: ;
			endcase
			tk[n] = '{sts_pkg::TK_EOF, p, '0, line_q, sts_pkg::ERR_NONE, 1'b0};
			n = n + 2'd1;
			mode_d = sts_pkg::M_IDLE; held_d = sts_pkg::H_NONE; begin_d = '0;
			pos_d = '0; line_d = LB'(1); kw_d = '0; qp_d = 1'b0;
		end else begin
			case (mode_q)
				sts_pkg::M_IDLE: begin
					fresh = 1'b1;
					if (held_q == sts_pkg::H_SLASH) begin
						held_d = sts_pkg::H_NONE;
						if (c == "/") begin
							mode_d = sts_pkg::M_COMMENT; fresh = 1'b0; done = 1'b1;
						end else begin
							tk[n] = '{sts_pkg::TK_ERROR, begin_q, NB'(1), line_q,
								sts_pkg::ERR_UNEXPECTED, 1'b0};
							n = n + 2'd1;
						end
					end else if (held_q == sts_pkg::H_AT) begin
						held_d = sts_pkg::H_NONE;
						if (sts_pkg::char_letter(c)) begin
							mode_d = sts_pkg::M_IDENT; qp_d = 1'b1;
							kw_d = sts_pkg::kw_next(5'd0, c);
							fresh = 1'b0; done = 1'b1;
						end else if (sts_pkg::char_numeral(c)) begin
							mode_d = sts_pkg::M_INT; qp_d = 1'b1;
							fresh = 1'b0; done = 1'b1;
						end else begin
							tk[n] = '{sts_pkg::TK_ERROR, begin_q, NB'(1), line_q,
								sts_pkg::ERR_UNEXPECTED, 1'b0};
							n = n + 2'd1;
						end
					end
				end
				sts_pkg::M_IDENT: begin
					if (sts_pkg::char_letter(c) || sts_pkg::char_numeral(c)) begin
						kw_d = sts_pkg::kw_next(kw_q, c); done = 1'b1;
					end else begin
						k = sts_pkg::kw_kind(kw_q);
						tk[n] = '{5'd0, begin_q, sts_pkg::span(p, begin_q), line_q,
							sts_pkg::ERR_NONE, 1'b0};
						if (qp_q) begin
							if (k == sts_pkg::TK_TRUE) tk[n].token_kind = sts_pkg::TK_QTRUE;
							else if (k == sts_pkg::TK_FALSE) tk[n].token_kind = sts_pkg::TK_QFALSE;
							else begin
								tk[n].token_kind = sts_pkg::TK_ERROR;
								tk[n].error_kind = sts_pkg::ERR_UNEXPECTED;
							end
						end else tk[n].token_kind = (k != 5'd0) ? k : sts_pkg::TK_ID;
						n = n + 2'd1;
						fresh = 1'b1;
					end
				end
				sts_pkg::M_INT: begin
					if (held_q == sts_pkg::H_DOT) begin
						held_d = sts_pkg::H_NONE;
						if (sts_pkg::char_numeral(c)) begin
							mode_d = sts_pkg::M_FRAC; done = 1'b1;
						end else begin
							tk[n] = '{qp_q ? sts_pkg::TK_QNUMBER : sts_pkg::TK_NUMBER, begin_q,
								sts_pkg::span(p - PB'(1), begin_q), line_q, sts_pkg::ERR_NONE, 1'b0};
							n = n + 2'd1;
							tk[n] = '{sts_pkg::TK_DOT, p - PB'(1), NB'(1), line_q,
								sts_pkg::ERR_NONE, 1'b0};
							n = n + 2'd1;
							fresh = 1'b1;
						end
					end else if (sts_pkg::char_numeral(c)) done = 1'b1;
					else if (c == ".") begin
						held_d = sts_pkg::H_DOT; done = 1'b1;
					end else begin
						tk[n] = '{qp_q ? sts_pkg::TK_QNUMBER : sts_pkg::TK_NUMBER, begin_q,
							sts_pkg::span(p, begin_q), line_q, sts_pkg::ERR_NONE, 1'b0};
						n = n + 2'd1;
						fresh = 1'b1;
					end
				end
				sts_pkg::M_FRAC: begin
					if (sts_pkg::char_numeral(c)) done = 1'b1;
					else begin
						tk[n] = '{qp_q ? sts_pkg::TK_QNUMBER : sts_pkg::TK_NUMBER, begin_q,
							sts_pkg::span(p, begin_q), line_q, sts_pkg::ERR_NONE, 1'b0};
						n = n + 2'd1;
						fresh = 1'b1;
					end
				end
				sts_pkg::M_STRING: begin
					done = 1'b1;
					if (c == "\"") begin
						// length includes the closing quote; saturating step so a
						// string already at the maximum length does not wrap
						tk[n] = '{sts_pkg::TK_STRING, begin_q, sts_pkg::span(p, begin_q),
							line_q, sts_pkg::ERR_NONE, 1'b0};
						if (tk[n].token_length != sts_pkg::LEN_MAX)
							tk[n].token_length = tk[n].token_length + NB'(1);
						n = n + 2'd1;
						mode_d = sts_pkg::M_IDLE;
					end else if (c == "\n" && line_q != sts_pkg::LINE_MAX)
						line_d = line_q + LB'(1);
				end
				sts_pkg::M_COMMENT: begin
					if (c == "\n") fresh = 1'b1;
					else done = 1'b1;
				end
				default: fresh = 1'b1;
			endcase

			if (fresh) begin
				mode_d = sts_pkg::M_IDLE; held_d = sts_pkg::H_NONE; qp_d = 1'b0;
				begin_d = p;
				if (c == " " || c == "," || c == ";" || c == "\r" || c == "\t") ;
				else if (c == "\n") begin
					if (line_q != sts_pkg::LINE_MAX) line_d = line_q + LB'(1);
				end else if (c == "/") held_d = sts_pkg::H_SLASH;
				else if (c == "@") held_d = sts_pkg::H_AT;
				else if (sts_pkg::char_letter(c)) begin
					mode_d = sts_pkg::M_IDENT; kw_d = sts_pkg::kw_next(5'd0, c);
				end else if (sts_pkg::char_numeral(c)) mode_d = sts_pkg::M_INT;
				else if (c == "\"") mode_d = sts_pkg::M_STRING;
				else begin
					k = sts_pkg::punct_kind(c);
					if (k != 5'd0) tk[n] = '{k, p, NB'(1), line_q, sts_pkg::ERR_NONE, 1'b0};
					else tk[n] = '{sts_pkg::TK_ERROR, p, NB'(1), line_q,
						sts_pkg::ERR_UNEXPECTED, 1'b0};
					n = n + 2'd1;
				end
				done = 1'b1;
			end
			if (done && pos_q != sts_pkg::POS_MAX) pos_d = pos_q + PB'(1);
		end
		// tokens carry the line count at completion; the newline that
		// finishes a token bumps the count only after it is emitted
		if (n != 2'd0) tk[n-2'd1].last_of_run = 1'b1;
	end

	assign run_valid = fire && (n != 2'd0);
	assign run = '{n, tk[0], tk[1], tk[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sts_pkg::M_IDLE;
			held_q  <= sts_pkg::H_NONE;
			begin_q <= '0;
			pos_q   <= '0;
			line_q  <= LB'(1);
			kw_q    <= '0;
			qp_q    <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			held_q  <= held_d;
			begin_q <= begin_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
			kw_q    <= kw_d;
			qp_q    <= qp_d;
		end
	end
endmodule
`default_nettype wire

@@ hdl/sts_queue.sv @@
// ----------------------------------------------------------------------------
// sts_queue - short run queue between front and back
// Four entries; full is the registered count alone, ignoring a same-cycle pop.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sts_pkg::run_t  push_run,
	output logic                full,
	output logic                not_empty,
	input  wire logic           pop,
	output sts_pkg::run_t       head
);
	sts_pkg::run_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full      = cnt_q == 3'd4;
	assign not_empty = cnt_q != 3'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule
`default_nettype wire

@@ hdl/sts_back.sv @@
// ----------------------------------------------------------------------------
// sts_back - token issuer
// Takes a queued run apart and hands tokens out one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_not_empty,
	input  wire sts_pkg::run_t  q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output sts_pkg::out_req_t   out_req
);
	logic [1:0] idx_q;
	logic       last;

	assign out_valid = q_not_empty;
	always_comb begin
		case (idx_q)
			2'd0:    out_req = q_head.t0;
			2'd1:    out_req = q_head.t1;
			default: out_req = q_head.t2;
		endcase
	end
	assign last  = (idx_q + 2'd1) == q_head.count;
	assign q_pop = q_not_empty && !out_stall && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (q_not_empty && !out_stall) idx_q <= last ? 2'd0 : idx_q + 2'd1;
	end
endmodule
`default_nettype wire

@@ hdl/source_token_scanner.sv @@
// ----------------------------------------------------------------------------
// source_token_scanner - streaming lexer, one source byte per request
// Front scans bytes into token runs, a four-run queue decouples the back,
// which issues one token per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// The front writes each completed run into the queue; the back issues it.
// Throughput: one byte per cycle unless the queue is full, one token per
// cycle unless stalled; a run of two or three tokens holds the back longer.
// Reset: asynchronous, clears scan state to idle, line 1, offset 0, queue
// empty. After an end-of-source request the front returns to that scan state.
`default_nettype none
module source_token_scanner (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sts_pkg::in_req_t   in_req,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sts_pkg::out_req_t       out_req
);
	logic          run_valid, q_full, q_not_empty, q_pop;
	sts_pkg::run_t run, q_head;

	// front: classification, keyword trie and positions
	sts_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_req,
		.run_valid, .run_full(q_full), .run
	);

	// queue of token runs
	sts_queue u_queue (
		.clk, .arst_n, .push(run_valid), .push_run(run), .full(q_full),
		.not_empty(q_not_empty), .pop(q_pop), .head(q_head)
	);

	// back: serialises each run onto the output
	sts_back u_back (
		.clk, .arst_n, .q_not_empty, .q_head, .q_pop,
		.out_valid, .out_stall, .out_req
	);
endmodule
`default_nettype wire
